// ===== design/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg: stereo linear resampler shared definitions
// Register map, fixed field widths, defaults and the sequencer-to-merge
// issue record.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int GAIN_W      = 9;
	localparam int COUNT_W     = 16;
	localparam int GAIN_SHIFT  = 8;
	localparam int MAX_RESULTS = 64;
	localparam int FIFO_DEPTH  = 4;

	localparam int GAIN_RESET  = 256;
	localparam int COUNT_RESET = 1024;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP   = 2'd0,
		CFG_VOLUME_GAIN  = 2'd1,
		CFG_OUTPUT_COUNT = 2'd2
	} cfg_index_t;

	// one output computation launched into both lanes
	typedef struct packed {
		logic valid;
		logic done;
	} slr_issue_t;

endpackage

`default_nettype wire

// ===== design/slr_in_if.sv =====
// ----------------------------------------------------------------------------
// slr_in_if: input frame channel
// Valid/ready channel carrying one stereo input frame and its last-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface slr_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;
	logic                          final_frame;

	modport source (output valid, output left_in, output right_in, output final_frame,
		input ready);
	modport sink (input valid, input left_in, input right_in, input final_frame,
		output ready);
endinterface

`default_nettype wire

// ===== design/slr_out_if.sv =====
// ----------------------------------------------------------------------------
// slr_out_if: output frame channel
// Valid/ready channel carrying one resampled stereo frame and the block-end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface slr_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          block_done;

	modport source (output valid, output left_out, output right_out, output block_done,
		input ready);
	modport sink (input valid, input left_out, input right_out, input block_done,
		output ready);
endinterface

`default_nettype wire

// ===== design/slr_lane.sv =====
// ----------------------------------------------------------------------------
// slr_lane: one channel of the interpolator
// held + (next - held) * position, times gain, rounded half away from zero
// and saturated. Three register stages; the rounding is combinational on
// the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_lane import slr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic signed [SAMPLE_BITS-1:0] held,
	input  wire logic signed [SAMPLE_BITS-1:0] next,
	input  wire logic signed [FRAC_BITS+7:0]   pos,
	input  wire logic        [GAIN_W-1:0]      gain,
	output logic signed      [SAMPLE_BITS-1:0] sample
);
	localparam int POS_W  = FRAC_BITS + 8;
	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int MUL_W  = DIFF_W + POS_W;
	localparam int IW     = MUL_W + 1;
	localparam int PW     = IW + GAIN_W + 1;
	localparam int SH     = FRAC_BITS + GAIN_SHIFT;
	localparam int RW     = PW - SH + 1;

	localparam logic [PW:0]   HALF    = (PW+1)'(1) << (SH - 1);
	localparam logic [RW-1:0] LIM_POS = RW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic [RW-1:0] LIM_NEG = RW'(1 << (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS-1:0] a_s1;
	logic signed [DIFF_W-1:0]      diff_s1;
	logic signed [POS_W-1:0]       pos_s1;
	logic signed [IW-1:0]          interp_s2;
	logic signed [PW-1:0]          prod_s3;

	logic signed [MUL_W-1:0] mul_c;
	logic signed [PW-1:0]    scaled_c;
	logic                    neg_c;
	logic        [PW-1:0]    mag_c;
	logic        [PW:0]      rnd_c;
	logic        [RW-1:0]    r_c;

	assign mul_c    = diff_s1 * pos_s1;
	assign scaled_c = interp_s2 * $signed({1'b0, gain});

	always_ff @(posedge clk) begin
		a_s1      <= held;
		diff_s1   <= DIFF_W'(next) - DIFF_W'(held);
		pos_s1    <= pos;
		interp_s2 <= (IW'(a_s1) <<< FRAC_BITS) + IW'(mul_c);
		prod_s3   <= scaled_c;
	end

	always_comb begin
		neg_c = prod_s3[PW-1];
		mag_c = neg_c ? (~prod_s3 + PW'(1)) : prod_s3;
		rnd_c = {1'b0, mag_c} + HALF;
		r_c   = rnd_c[PW:SH];
		if (!neg_c) begin
			sample = (r_c > LIM_POS) ? SMAX : $signed(r_c[SAMPLE_BITS-1:0]);
		end else begin
			sample = (r_c >= LIM_NEG) ? SMIN : -$signed(r_c[SAMPLE_BITS-1:0]);
		end
	end

endmodule

`default_nettype wire

// ===== design/slr_ctrl.sv =====
// ----------------------------------------------------------------------------
// slr_ctrl: frame sequencer and configuration registers
// Holds the previous frame, phase and output count; steps the phase through
// outputs before each frame, within the count and MAX_RESULTS per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_ctrl import slr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int CFG_W       = 23
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	slr_in_if.sink                             frames,
	input  wire logic                          cfg_we,
	input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic        [CFG_W-1:0]       cfg_data,
	input  wire logic                          credit_ok,
	output slr_issue_t                         issue,
	output logic signed      [SAMPLE_BITS-1:0] held_l,
	output logic signed      [SAMPLE_BITS-1:0] next_l,
	output logic signed      [SAMPLE_BITS-1:0] held_r,
	output logic signed      [SAMPLE_BITS-1:0] next_r,
	output logic signed      [FRAC_BITS+7:0]   pos,
	output logic             [GAIN_W-1:0]      gain
);
	localparam int STEP_W = FRAC_BITS + 7;
	localparam int POS_W  = FRAC_BITS + 8;
	localparam int N_W    = $clog2(MAX_RESULTS + 1);

	localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1) << (FRAC_BITS - 5);
	localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(64) << FRAC_BITS;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;
	localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAIN,
		ST_TAIL
	} state_t;

	state_t                        state_q;
	logic signed [SAMPLE_BITS-1:0] held_l_q, held_r_q, cur_l_q, cur_r_q;
	logic                          last_q;
	logic signed [POS_W-1:0]       pos_q;
	logic                          have_first_q;
	logic        [COUNT_W-1:0]     emitted_q;
	logic        [N_W-1:0]         n_q;
	logic        [STEP_W-1:0]      step_q;
	logic        [GAIN_W-1:0]      gain_q;
	logic        [COUNT_W-1:0]     count_q;

	logic        [STEP_W-1:0]      step_c;
	logic signed [POS_W-1:0]       start_c;
	logic                          more_c;
	logic                          accept_c;

	always_comb begin
		if (step_q < STEP_MIN) begin
			step_c = STEP_MIN;
		end else if (step_q > STEP_MAX) begin
			step_c = STEP_MAX;
		end else begin
			step_c = step_q;
		end
	end

	assign start_c  = -$signed(POS_W'(step_c >> 1));
	assign more_c   = (pos_q < POS_ONE) && (emitted_q < count_q)
		&& (n_q < N_W'(MAX_RESULTS));
	assign accept_c = frames.valid && frames.ready;

	assign frames.ready = (state_q == ST_IDLE);
	assign issue.valid  = (state_q != ST_IDLE) && more_c && credit_ok;
	assign issue.done   = ((COUNT_W+1)'(emitted_q) + (COUNT_W+1)'(1)) == {1'b0, count_q};
	assign held_l = held_l_q;
	assign held_r = held_r_q;
	// the tail of a last frame repeats the held frame
	assign next_l = (state_q == ST_MAIN) ? cur_l_q : held_l_q;
	assign next_r = (state_q == ST_MAIN) ? cur_r_q : held_r_q;
	assign pos    = pos_q;
	assign gain   = gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			held_l_q     <= '0;
			held_r_q     <= '0;
			cur_l_q      <= '0;
			cur_r_q      <= '0;
			last_q       <= 1'b0;
			pos_q        <= -$signed(POS_W'(STEP_RESET >> 1));
			have_first_q <= 1'b0;
			emitted_q    <= '0;
			n_q          <= '0;
			step_q       <= STEP_RESET;
			gain_q       <= GAIN_W'(GAIN_RESET);
			count_q      <= COUNT_W'(COUNT_RESET);
		end else begin
			if (cfg_we) begin
				case (cfg_index_t'(cfg_index))
					CFG_PHASE_STEP:   step_q  <= cfg_data[STEP_W-1:0];
					CFG_VOLUME_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
					CFG_OUTPUT_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						cur_l_q <= frames.left_in;
						cur_r_q <= frames.right_in;
						last_q  <= frames.final_frame;
						n_q     <= '0;
						if (!have_first_q) begin
							// first frame of a block is only held
							have_first_q <= 1'b1;
							emitted_q    <= '0;
							pos_q        <= start_c;
							held_l_q     <= frames.left_in;
							held_r_q     <= frames.right_in;
							state_q      <= frames.final_frame ? ST_TAIL : ST_IDLE;
						end else if (emitted_q < count_q) begin
							state_q <= ST_MAIN;
						end else begin
							held_l_q <= frames.left_in;
							held_r_q <= frames.right_in;
							state_q  <= frames.final_frame ? ST_TAIL : ST_IDLE;
						end
					end
				end
				ST_MAIN: begin
					if (more_c) begin
						if (credit_ok) begin
							emitted_q <= emitted_q + COUNT_W'(1);
							n_q       <= n_q + N_W'(1);
							pos_q     <= pos_q + $signed(POS_W'(step_c));
						end
					end else begin
						pos_q    <= pos_q - POS_ONE;
						held_l_q <= cur_l_q;
						held_r_q <= cur_r_q;
						state_q  <= last_q ? ST_TAIL : ST_IDLE;
					end
				end
				ST_TAIL: begin
					if (more_c) begin
						if (credit_ok) begin
							emitted_q <= emitted_q + COUNT_W'(1);
							n_q       <= n_q + N_W'(1);
							pos_q     <= pos_q + $signed(POS_W'(step_c));
						end
					end else begin
						have_first_q <= 1'b0;
						emitted_q    <= '0;
						pos_q        <= start_c;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/slr_merge.sv =====
// ----------------------------------------------------------------------------
// slr_merge: lane merge and result queue
// Tracks outputs in flight through the lanes, pairs the two lane samples
// with the block-end flag and queues them for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_merge import slr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire slr_issue_t                    issue,
	input  wire logic signed [SAMPLE_BITS-1:0] lane_l,
	input  wire logic signed [SAMPLE_BITS-1:0] lane_r,
	output logic                               credit_ok,
	slr_out_if.source                          results
);
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	logic v_s1, v_s2, v_s3;
	logic d_s1, d_s2, d_s3;

	logic signed [SAMPLE_BITS-1:0] left_q  [FIFO_DEPTH];
	logic signed [SAMPLE_BITS-1:0] right_q [FIFO_DEPTH];
	logic                          done_q  [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic pop_c;

	// queue entries plus lane stages must stay within the queue depth
	assign credit_ok = ({1'b0, count_q} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(v_s2)
		+ (CNT_W+1)'(v_s3)) < (CNT_W+1)'(FIFO_DEPTH);

	assign results.valid      = (count_q != '0);
	assign results.left_out   = left_q[rd_ptr_q];
	assign results.right_out  = right_q[rd_ptr_q];
	assign results.block_done = done_q[rd_ptr_q];
	assign pop_c = results.valid && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			v_s1 <= issue.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_c) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(v_s3) - CNT_W'(pop_c);
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= issue.done;
		d_s2 <= d_s1;
		d_s3 <= d_s2;
		if (v_s3) begin
			left_q[wr_ptr_q]  <= lane_l;
			right_q[wr_ptr_q] <= lane_r;
			done_q[wr_ptr_q]  <= d_s3;
		end
	end

endmodule

`default_nettype wire

// ===== design/stereo_linear_resampler_top.sv =====
// ----------------------------------------------------------------------------
// stereo_linear_resampler_top: stereo linear-interpolation resampler
// Resamples stereo frames by phase_step with volume scaling and saturation.
//
// frames:  valid/ready input, one stereo frame per transfer, final_frame on
//          the last frame of a block. results: valid/ready output, one
//          resampled frame per transfer, block_done on the last of a block.
// cfg:     cfg_we/cfg_index/cfg_data write port; 0 phase_step (Q7.16 input
//          frames per output), 1 volume_gain (1/256 units), 2 output_count.
//          Write only while the block is idle.
// Flow:    a frame producing outputs holds the sequencer while it launches them,
//          plus credit waits; a last frame then adds its tail outputs; a frame
//          that only replaces the held frame returns it to idle. Each result
//          passes the lane registers and the result queue before it leaves.
// Stalls:  a launch needs queue entries plus lane outputs below four, which
//          can hold a launch even with the receiver ready; when the receiver
//          stalls the sequencer pauses and frames wait.
// Reset:   registers return to step 1.0, gain 256, count 1024; the first
//          frame after reset or after a last frame only starts a block.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler_top import slr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int CFG_W       = ((FRAC_BITS + 7) > COUNT_W) ? (FRAC_BITS + 7) : COUNT_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	slr_in_if.sink                    frames,
	slr_out_if.source                 results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	slr_issue_t                    issue;
	logic                          credit_ok;
	logic signed [SAMPLE_BITS-1:0] held_l, next_l, held_r, next_r;
	logic signed [SAMPLE_BITS-1:0] lane_l, lane_r;
	logic signed [FRAC_BITS+7:0]   pos;
	logic        [GAIN_W-1:0]      gain;

	slr_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.CFG_W       (CFG_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.frames    (frames),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.credit_ok (credit_ok),
		.issue     (issue),
		.held_l    (held_l),
		.next_l    (next_l),
		.held_r    (held_r),
		.next_r    (next_r),
		.pos       (pos),
		.gain      (gain)
	);

	slr_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_lane_l (
		.clk    (clk),
		.held   (held_l),
		.next   (next_l),
		.pos    (pos),
		.gain   (gain),
		.sample (lane_l)
	);

	slr_lane #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_lane_r (
		.clk    (clk),
		.held   (held_r),
		.next   (next_r),
		.pos    (pos),
		.gain   (gain),
		.sample (lane_r)
	);

	slr_merge #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.lane_l    (lane_l),
		.lane_r    (lane_r),
		.credit_ok (credit_ok),
		.results   (results)
	);

	// no frame is taken while outputs of the current one are still launching
	a_issue_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> !frames.ready)
		else $error("output launched while frame channel ready");

	// the output that completes the count is the last of the block
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid && issue.done |=> !issue.valid)
		else $error("output launched after block count reached");

	// launches only with room reserved in the result queue
	a_issue_credit: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> credit_ok)
		else $error("output launched without queue space");

endmodule

`default_nettype wire
